// File: sv/sfm_pkg.sv
// Package for the substring first-match finder: item types, register
// indexes and sizing constants. No dependencies.
package sfm_pkg;

  // pattern and position sizing
  localparam int unsigned MaxPattern = 8;
  localparam int unsigned WindowW    = MaxPattern * 8;
  localparam int unsigned OffsetW    = 16;
  localparam int unsigned LenW       = 4;
  localparam int unsigned LenIdxW    = $clog2(MaxPattern);
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned CfgDataW   = 64;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_BYTES  = 1'b0,
    CFG_PATTERN_LENGTH = 1'b1
  } cfg_index_e;

  // one text byte
  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  // one search result
  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] match_offset;
  } out_item_t;

endpackage

// File: sv/substring_first_match_finder.sv
// Substring first-match finder top level: input register, window compare,
// result register. Depends on sfm_pkg.
//
// The block takes text one byte per item, with end_of_text marking the last
// byte of each string, and reports once per string: the start offset of the
// first occurrence of the configured pattern (1 to 8 bytes, byte 0 first),
// or found = 0 on the last byte when no match occurred. The pattern is
// compared combinationally against a sliding 8-byte window, so one byte is
// taken every clock while the result is not stalled; a byte is captured in
// the input register and its result is loaded into the result register
// once that register is free. A stalled result holds
// the input register and in turn stalls the input.
// The position count saturates at 65535. Registers should be written only
// while no bytes are in flight.
module substring_first_match_finder
  import sfm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  logic [WindowW-1:0] pat_q;
  logic [LenW-1:0]    plen_q;

  // input stage
  logic     in_valid_q;
  in_item_t in_q;

  // string state
  logic [WindowW-1:0] win_q, win_d;
  logic [OffsetW-1:0] cnt_q, cnt_d;
  logic               rep_q, rep_d;

  // result stage
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  logic               out_free;
  logic               s1_fire;
  logic               in_load;
  logic [LenW-1:0]    len_eff;
  logic [LenIdxW-1:0] len_idx;
  logic [WindowW-1:0] win_next;
  logic [OffsetW-1:0] cnt_next;
  logic [MaxPattern-1:0] match_len;
  logic               hit;
  logic               res_valid;
  out_item_t          res;

  // pipeline control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_fire    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_load    = in_valid_i && !in_stall_o;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      plen_q <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PATTERN_BYTES:  pat_q  <= cfg_wdata_i[WindowW-1:0];
        CFG_PATTERN_LENGTH: plen_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  // clamp length into 1..MaxPattern
  always_comb begin
    if (plen_q == '0) begin
      len_eff = LenW'(1);
    end else if (plen_q > LenW'(MaxPattern)) begin
      len_eff = LenW'(MaxPattern);
    end else begin
      len_eff = plen_q;
    end
  end

  // select line for the per-length compare results
  assign len_idx = LenIdxW'(len_eff - LenW'(1));

  // window shift and saturating count
  assign win_next = {win_q[WindowW-9:0], in_q.text_byte};
  assign cnt_next = (cnt_q == '1) ? cnt_q : cnt_q + OffsetW'(1);

  // compare for every possible length; pattern byte k against window byte l-1-k
  always_comb begin
    for (int l = 1; l <= MaxPattern; l++) begin
      match_len[l-1] = 1'b1;
      for (int k = 0; k < l; k++) begin
        if (win_next[(l-1-k)*8 +: 8] != pat_q[k*8 +: 8]) begin
          match_len[l-1] = 1'b0;
        end
      end
    end
  end

  assign hit = !rep_q && (cnt_next >= OffsetW'(len_eff))
               && match_len[len_idx];

  // result and next string state
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    win_d     = win_q;
    cnt_d     = cnt_q;
    rep_d     = rep_q;
    if (s1_fire) begin
      win_d = win_next;
      cnt_d = cnt_next;
      if (hit) begin
        res_valid        = 1'b1;
        res.found        = 1'b1;
        res.match_offset = (cnt_next == '1) ? cnt_next : cnt_next - OffsetW'(len_eff);
        rep_d            = 1'b1;
      end else if (in_q.end_of_text && !rep_q) begin
        res_valid = 1'b1;
      end
      if (in_q.end_of_text) begin
        win_d = '0;
        cnt_d = '0;
        rep_d = 1'b0;
      end
    end
  end

  // result register next value
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_free) begin
      out_valid_d = res_valid;
      out_d       = res;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      win_q       <= '0;
      cnt_q       <= '0;
      rep_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_load) begin
        in_valid_q <= 1'b1;
      end else if (s1_fire) begin
        in_valid_q <= 1'b0;
      end
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      rep_q       <= rep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_q <= in_item_i;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  // a not-found result always carries a zero offset
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.found |-> out_q.match_offset == '0)
    else $error("not-found result with nonzero offset");

  // a reported match implies bytes were counted in this string
  a_rep_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_q |-> cnt_q != '0)
    else $error("reported flag set with empty count");

  // a match inside a string sets the reported flag
  a_hit_sets_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && hit && !in_q.end_of_text |=> rep_q)
    else $error("match did not set reported flag");

  // input stall only when an item is held
  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("stall without pending item");
`endif

endmodule

// File: tb/tb_substring_first_match_finder.sv
`timescale 1ns / 1ps
// Testbench for substring_first_match_finder: streams text strings through the
// block, predicts each first-match report and checks it field by field.
// Depends on sfm_pkg and the substring_first_match_finder top level.
module tb_substring_first_match_finder;
  import sfm_pkg::*;

  localparam int unsigned DrainCycles = 6;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned LongRun     = 20;

  logic       clk_i;
  logic       rst_ni        = 1'b0;
  logic       in_valid      = 1'b0;
  in_item_t   in_item       = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       out_stall     = 1'b0;
  out_item_t  out_item_o;
  logic       cfg_we        = 1'b0;
  cfg_index_e cfg_index     = CFG_PATTERN_BYTES;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  // local copy of the registers and the per-string search state
  logic [WindowW-1:0] pat_cfg  = '0;
  logic [LenW-1:0]    plen_cfg = 4'd1;
  logic [WindowW-1:0] win      = '0;
  logic [OffsetW-1:0] seen     = '0;
  logic               reported = 1'b0;

  in_item_t  text_q [$];
  out_item_t reports_due [$];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned errors          = 0;
  int unsigned bytes_taken     = 0;
  int unsigned strings_done    = 0;
  int unsigned n_found         = 0;
  int unsigned n_missed        = 0;
  int unsigned quiet_cycles    = 0;

  int unsigned send_idle [4]  = '{0, 61, 0, 27};
  int unsigned recv_stall [4] = '{0, 0, 61, 27};
  int unsigned seg_len [12]   = '{8, 1, 3, 0, 15, 5, 2, 9, 7, 4, 6, 8};

  substring_first_match_finder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // pattern length as the block uses it: 0 counts as 1, above 8 as 8
  function automatic int unsigned pattern_span();
    if (plen_cfg == 0) return 1;
    if (plen_cfg > MaxPattern) return MaxPattern;
    return 32'(plen_cfg);
  endfunction

  // advance the search by one text byte and queue any report it causes
  task automatic scan_byte(input in_item_t it);
    int unsigned span;
    logic        hit;
    out_item_t   rep;
    span = pattern_span();
    win  = {win[WindowW-9:0], it.text_byte};
    if (seen != '1) seen++;
    hit = !reported && (seen >= span);
    for (int k = 0; k < span; k++)
      if (win[8*(span-1-k) +: 8] != pat_cfg[8*k +: 8]) hit = 1'b0;
    if (hit) begin
      rep.found        = 1'b1;
      rep.match_offset = (seen != '1) ? OffsetW'(seen - span) : '1;
      reports_due.push_back(rep);
      reported = 1'b1;
    end else if (it.end_of_text && !reported) begin
      rep = '0;
      reports_due.push_back(rep);
    end
    if (it.end_of_text) begin
      win      = '0;
      seen     = '0;
      reported = 1'b0;
    end
  endtask

  // register write while nothing is in flight
  task automatic write_reg(input cfg_index_e idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PATTERN_BYTES:  pat_cfg  = val;
      CFG_PATTERN_LENGTH: plen_cfg = val[LenW-1:0];
      default: ;
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b, input logic last);
    in_item_t it;
    it.text_byte   = b;
    it.end_of_text = last;
    text_q.push_back(it);
  endtask

  // wait for all text taken and all reports in, then let the pipeline drain
  task automatic settle();
    do @(negedge clk_i);
    while (text_q.size() != 0 || in_valid || reports_due.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // random strings built mostly from the pattern's own bytes, some with the
  // whole pattern planted, some with a planted copy broken, some pure noise
  task automatic queue_strings(input int unsigned budget);
    int unsigned added;
    int unsigned span;
    int unsigned slen;
    int unsigned at;
    int unsigned j;
    logic        noise;
    logic [7:0]  txt [$];
    added = 0;
    span  = pattern_span();
    while (added < budget) begin
      slen  = $urandom_range(24, 1);
      noise = ($urandom_range(4) == 0);
      txt.delete();
      for (int i = 0; i < slen; i++) begin
        if (noise || $urandom_range(9) == 0) txt.push_back(8'($urandom));
        else txt.push_back(pat_cfg[8*$urandom_range(span-1) +: 8]);
      end
      if (!noise && slen >= span && $urandom_range(1) == 1) begin
        at = $urandom_range(slen - span);
        for (int k = 0; k < span; k++) txt[at+k] = pat_cfg[8*k +: 8];
        if ($urandom_range(3) == 0) begin
          j = at + $urandom_range(span - 1);
          txt[j] = txt[j] ^ (8'h01 << $urandom_range(7));
        end
      end
      for (int i = 0; i < slen; i++) add_byte(txt[i], i == slen - 1);
      added += slen;
    end
  endtask

  // text driver: holds an item until taken, idles at random
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        scan_byte(in_item);
        bytes_taken++;
        if (in_item.end_of_text) strings_done++;
      end
      if (!in_valid || !in_stall_o) begin
        if (text_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= text_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor: random stall, compare with the oldest pending report
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall) begin
        if (reports_due.size() == 0) begin
          $display("%0t: report with none pending, got found %0d offset %0d",
                   $time, out_item_o.found, out_item_o.match_offset);
          errors++;
        end else begin
          want = reports_due.pop_front();
          if (out_item_o.found !== want.found) begin
            $display("%0t: found mismatch, expected %0d, got %0d",
                     $time, want.found, out_item_o.found);
            errors++;
          end
          if (out_item_o.match_offset !== want.match_offset) begin
            $display("%0t: match_offset mismatch, expected %0d, got %0d",
                     $time, want.match_offset, out_item_o.match_offset);
            errors++;
          end
          if (want.found) n_found++;
          else n_missed++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // watchdog on cycles where neither side moves an item
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [WindowW-1:0] pat;
    logic [7:0]         sym_a;
    logic [7:0]         sym_b;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero-byte pattern, length 0 taken as 1, match on the last byte
    write_reg(CFG_PATTERN_BYTES, '0);
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    add_byte(8'h00, 1'b1);
    settle();

    // zero window must not match before eight bytes have arrived
    write_reg(CFG_PATTERN_LENGTH, 64'd8);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h00, 1'b1);
    settle();

    // all-ones pattern, length 15 clipped to 8, match ends on the last byte
    write_reg(CFG_PATTERN_BYTES, '1);
    write_reg(CFG_PATTERN_LENGTH, 64'd15);
    add_byte(8'h12, 1'b0);
    for (int i = 0; i < 8; i++) add_byte(8'hFF, i == 7);
    settle();

    // overlapping prefix, then the later bytes and the end give nothing more
    write_reg(CFG_PATTERN_BYTES, 64'h424141);
    write_reg(CFG_PATTERN_LENGTH, 64'd3);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b0);
    add_byte(8'h41, 1'b0);
    add_byte(8'h42, 1'b1);
    settle();

    // pattern changed in the middle of a string, window kept
    add_byte(8'h41, 1'b0);
    add_byte(8'h41, 1'b0);
    settle();
    write_reg(CFG_PATTERN_BYTES, 64'h4341);
    write_reg(CFG_PATTERN_LENGTH, 64'd2);
    add_byte(8'h43, 1'b1);
    settle();

    // a run of zeros before the match, then a byte after it
    write_reg(CFG_PATTERN_BYTES, 64'hA55A);
    for (int i = 0; i < LongRun; i++) add_byte(8'h00, 1'b0);
    add_byte(8'h5A, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h00, 1'b1);
    settle();

    // random strings under each pacing mode and several pattern settings
    for (int ph = 0; ph < 4; ph++) begin
      sender_idle_pct = send_idle[ph];
      recv_stall_pct  = recv_stall[ph];
      for (int s = 0; s < 3; s++) begin
        if (s == 2) begin
          pat = {$urandom, $urandom};
        end else begin
          sym_a = $urandom;
          sym_b = $urandom;
          for (int k = 0; k < MaxPattern; k++)
            pat[8*k +: 8] = $urandom_range(1) ? sym_a : sym_b;
        end
        write_reg(CFG_PATTERN_BYTES, pat);
        write_reg(CFG_PATTERN_LENGTH, 64'(seg_len[ph*3+s]));
        queue_strings(45);
        settle();
      end
    end

    $display("searched %0d text bytes in %0d strings: %0d matches, %0d without a match",
             bytes_taken, strings_done, n_found, n_missed);
    $display("pattern lengths 0 to 15, mid-string pattern change and four pacing modes exercised");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
